/* design/pnmp_pkg.sv */
package pnmp_pkg;

    // Parser phase codes
    typedef enum logic [3:0] {
        PH_MAGIC0    = 4'd0,
        PH_MAGIC1    = 4'd1,
        PH_WIDTH     = 4'd2,
        PH_HEIGHT    = 4'd3,
        PH_MAXVAL    = 4'd4,
        PH_BODY      = 4'd5,
        PH_ERR_MAGIC = 4'd8,
        PH_ERR_NUM   = 4'd9,
        PH_ERR_SIZE  = 4'd10
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // End-of-file status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_NUM   = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_SIZE      = 3'd4;

    // Characters of the header syntax
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_5       = 8'h35;
    localparam logic [7:0] CH_6       = 8'h36;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_WS_LO   = 8'h09;
    localparam logic [7:0] CH_WS_HI   = 8'h0D;

    // Largest maxval that still means one byte per sample
    localparam int unsigned BYTE_MAX = 255;

    localparam logic [1:0] LAYERS_GREY   = 2'd1;
    localparam logic [1:0] LAYERS_COLOUR = 2'd3;

    // Result queue depth
    localparam int unsigned RQ_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] sample;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] max_value;
        logic [1:0]  layer_count;
        logic [2:0]  status;
        logic        final_res;
    } res_t;

    // Up to two results caused by one accepted byte
    typedef struct packed {
        logic [1:0] cnt;
        res_t       first;
        res_t       second;
    } push_t;

endpackage

/* design/pnmp_core.sv */
module pnmp_core
    import pnmp_pkg::*;
#(
    parameter int DIM_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] byte_in,
    input  logic       last_in,
    output push_t      push
);

    localparam int TW = DIM_BITS + 4;

    phase_t                phase_reg,  phase_next;
    logic                  in_comment_reg, in_comment_next;
    logic [DIM_BITS-1:0]   token_reg,  token_next;
    logic                  started_reg, started_next;
    logic [DIM_BITS-1:0]   width_reg,  width_next;
    logic [DIM_BITS-1:0]   height_reg, height_next;
    logic [DIM_BITS-1:0]   maxval_reg, maxval_next;
    logic [1:0]            layers_reg, layers_next;
    logic [DIM_BITS-1:0]   col_reg,    col_next;
    logic [DIM_BITS-1:0]   row_reg,    row_next;
    logic [1:0]            comp_reg,   comp_next;
    logic [7:0]            high_reg,   high_next;
    logic                  second_reg, second_next;

    logic                  is_ws;
    logic                  is_digit;
    logic [TW-1:0]         tok_new;
    logic                  body_full;
    logic                  full_after;
    logic                  emit_hdr;
    logic                  emit_smp;
    logic [15:0]           smp_val;
    logic [2:0]            end_status;
    res_t                  res_body;
    res_t                  res_end;

    assign is_ws    = (byte_in inside {CH_SPACE, [CH_WS_LO:CH_WS_HI]});
    assign is_digit = (byte_in inside {[CH_0:CH_9]});
    assign tok_new  = (TW'(token_reg) << 3) + (TW'(token_reg) << 1)
                    + TW'(byte_in[3:0]);
    assign body_full = (width_reg == '0) || (height_reg == '0) || (row_reg >= height_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        in_comment_next = in_comment_reg;
        token_next      = token_reg;
        started_next    = started_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        maxval_next     = maxval_reg;
        layers_next     = layers_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        comp_next       = comp_reg;
        high_next       = high_reg;
        second_next     = second_reg;
        emit_hdr        = 1'b0;
        emit_smp        = 1'b0;
        smp_val         = 16'd0;
        full_after      = 1'b0;
        end_status      = ST_OK;
        res_body        = '0;
        res_end         = '0;
        push            = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_MAGIC0:
                begin
                    phase_next = (byte_in == CH_P) ? PH_MAGIC1 : PH_ERR_MAGIC;
                end
                PH_MAGIC1:
                begin
                    if (byte_in == CH_5)
                    begin
                        layers_next = LAYERS_GREY;
                        phase_next  = PH_WIDTH;
                    end
                    else if (byte_in == CH_6)
                    begin
                        layers_next = LAYERS_COLOUR;
                        phase_next  = PH_WIDTH;
                    end
                    else
                    begin
                        phase_next = PH_ERR_MAGIC;
                    end
                end
                PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
                begin
                    if (in_comment_reg)
                    begin
                        if (byte_in == CH_NL)
                        begin
                            in_comment_next = 1'b0;
                        end
                    end
                    else if (is_ws || byte_in == CH_HASH)
                    begin
                        if (started_reg)
                        begin
                            token_next   = '0;
                            started_next = 1'b0;
                            if (phase_reg == PH_WIDTH)
                            begin
                                width_next      = token_reg;
                                phase_next      = PH_HEIGHT;
                                in_comment_next = (byte_in == CH_HASH);
                            end
                            else if (phase_reg == PH_HEIGHT)
                            begin
                                height_next     = token_reg;
                                phase_next      = PH_MAXVAL;
                                in_comment_next = (byte_in == CH_HASH);
                            end
                            else if (token_reg == '0)
                            begin
                                phase_next = PH_ERR_NUM;
                            end
                            else
                            begin
                                // separator byte after maxval: skip, never a comment
                                maxval_next = token_reg;
                                phase_next  = PH_BODY;
                                emit_hdr    = 1'b1;
                            end
                        end
                        else if (byte_in == CH_HASH)
                        begin
                            in_comment_next = 1'b1;
                        end
                    end
                    else if (is_digit)
                    begin
                        started_next = 1'b1;
                        token_next   = tok_new[DIM_BITS-1:0];
                        if (|tok_new[TW-1:DIM_BITS])
                        begin
                            phase_next = PH_ERR_NUM;
                        end
                    end
                    else
                    begin
                        phase_next = PH_ERR_NUM;
                    end
                end
                PH_BODY:
                begin
                    if (body_full)
                    begin
                        phase_next = PH_ERR_SIZE;
                    end
                    else if (maxval_reg > DIM_BITS'(BYTE_MAX) && !second_reg)
                    begin
                        high_next   = byte_in;
                        second_next = 1'b1;
                    end
                    else
                    begin
                        emit_smp    = 1'b1;
                        second_next = 1'b0;
                        smp_val     = second_reg ? {high_reg, byte_in} : {8'd0, byte_in};
                        // advance component, column, row
                        if ((comp_reg + 2'd1) >= layers_reg)
                        begin
                            comp_next = 2'd0;
                            if ((DIM_BITS+1)'(col_reg) + 1'b1 >= (DIM_BITS+1)'(width_reg))
                            begin
                                col_next = '0;
                                row_next = row_reg + 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            comp_next = comp_reg + 2'd1;
                        end
                    end
                end
                default:
                begin
                    // error phases: drop bytes until the last one
                end
            endcase

            full_after = (width_next == '0) || (height_next == '0)
                       || (row_next >= height_next);

            case (phase_next)
                PH_ERR_MAGIC: end_status = ST_BAD_MAGIC;
                PH_ERR_NUM:   end_status = ST_BAD_NUM;
                PH_ERR_SIZE:  end_status = ST_SIZE;
                PH_BODY:      end_status = (full_after && !second_next) ? ST_OK : ST_SIZE;
                default:      end_status = ST_TRUNC;
            endcase

            res_body.kind         = emit_hdr ? KIND_HEADER : KIND_SAMPLE;
            res_body.sample       = smp_val;
            res_body.image_width  = 16'(width_next);
            res_body.image_height = 16'(height_next);
            res_body.max_value    = 16'(maxval_next);
            res_body.layer_count  = layers_next;
            res_body.status       = ST_OK;
            res_body.final_res    = !last_in;

            res_end              = res_body;
            res_end.kind         = KIND_END;
            res_end.sample       = 16'd0;
            res_end.status       = end_status;
            res_end.final_res    = 1'b1;

            if (emit_hdr || emit_smp)
            begin
                push.first  = res_body;
                push.second = res_end;
                push.cnt    = last_in ? 2'd2 : 2'd1;
            end
            else if (last_in)
            begin
                push.first = res_end;
                push.cnt   = 2'd1;
            end

            // re-arm for the next file
            if (last_in)
            begin
                phase_next      = PH_MAGIC0;
                in_comment_next = 1'b0;
                token_next      = '0;
                started_next    = 1'b0;
                width_next      = '0;
                height_next     = '0;
                maxval_next     = '0;
                layers_next     = LAYERS_GREY;
                col_next        = '0;
                row_next        = '0;
                comp_next       = 2'd0;
                high_next       = 8'd0;
                second_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC0;
            in_comment_reg <= 1'b0;
            token_reg      <= '0;
            started_reg    <= 1'b0;
            width_reg      <= '0;
            height_reg     <= '0;
            maxval_reg     <= '0;
            layers_reg     <= LAYERS_GREY;
            col_reg        <= '0;
            row_reg        <= '0;
            comp_reg       <= 2'd0;
            high_reg       <= 8'd0;
            second_reg     <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            in_comment_reg <= in_comment_next;
            token_reg      <= token_next;
            started_reg    <= started_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            maxval_reg     <= maxval_next;
            layers_reg     <= layers_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            comp_reg       <= comp_next;
            high_reg       <= high_next;
            second_reg     <= second_next;
        end
    end

endmodule

/* design/pnmp_rq.sv */
module pnmp_rq
    import pnmp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    localparam int PW = $clog2(RQ_DEPTH);
    localparam int CW = $clog2(RQ_DEPTH + 1);

    res_t          q_reg [RQ_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pop;

    assign out_valid = (cnt_reg != '0);
    assign out_res   = q_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    // room for a full pair of results
    assign room      = (cnt_reg <= CW'(RQ_DEPTH - 2));

    always_comb
    begin
        wr_next  = wr_reg + PW'(push.cnt);
        rd_next  = rd_reg + PW'(pop);
        cnt_next = cnt_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            q_reg[wr_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            q_reg[wr_reg + PW'(1)] <= push.second;
        end
    end

endmodule

/* design/pnm_header_and_body_parser_top.sv */
// Channel  Dir  tdata (low bit up)                                  tuser  tlast
// s_*      in   byte_req[7:0]                                       -      is_final_byte
// m_*      out  sample, image_width, image_height, max_value,       kind   final_res
//               layer_count, status, 3 zero pad bits (72 bits)
//
// One byte is taken per cycle while s_tready is high; its results enter a four-entry
// result queue in the same cycle and leave its head one per cycle with m_tready high.
// A byte that closes the header or carries a sample and is also the last byte
// yields two results, so the output side sets the sustained rate there.
// s_tready drops while the queue cannot take a pair of results (more than two held).
// rst_n clears the parser to "expect magic" and empties the queue; the last
// byte of a file re-arms the parser for the next file.
module pnm_header_and_body_parser_top
    import pnmp_pkg::*;
#(
    parameter int DIM_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_req[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // sample, image_width, image_height, max_value,
                                   // layer_count, status, zero pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);

    logic  accept;
    push_t push;
    res_t  head;

    assign accept = s_tvalid && s_tready;

    // Parse the accepted item against the header/body state
    pnmp_core #(
        .DIM_BITS (DIM_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .byte_in (s_tdata),
        .last_in (s_tlast),
        .push    (push)
    );

    // Hold results until the sink takes them
    pnmp_rq u_rq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    assign m_tdata = {3'b000, head.status, head.layer_count, head.max_value,
                      head.image_height, head.image_width, head.sample};
    assign m_tuser = head.kind;
    assign m_tlast = head.final_res;

endmodule
